/* rtl/core/gga2igc_pkg.sv */
// Shared constants, types and queue entry format for the GGA to B record rewriter.
package gga2igc_pkg;

	localparam int TIME_DIGITS = 6;
	localparam int LAT_DIGITS  = 7;
	localparam int HEMI_DIGITS = 1;
	localparam int LON_DIGITS  = 8;
	localparam int ALT_DIGITS  = 5;

	localparam int FI_W   = 4;
	localparam int DL_W   = 5;
	localparam int AI_W   = $clog2(ALT_DIGITS);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Barometric value after clamping, and the reciprocal used to divide it by ten.
	localparam int VAL_W = 16;
	localparam int RECIP_SHIFT = 19;
	localparam logic [VAL_W-1:0] RECIP_TEN = 16'd52429;

	localparam logic [FI_W-1:0] FIELD_MAX = 4'd15;
	localparam logic [FI_W-1:0] F_TIME    = 4'd1;
	localparam logic [FI_W-1:0] F_LAT     = 4'd2;
	localparam logic [FI_W-1:0] F_HEMI_NS = 4'd3;
	localparam logic [FI_W-1:0] F_LON     = 4'd4;
	localparam logic [FI_W-1:0] F_HEMI_EW = 4'd5;
	localparam logic [FI_W-1:0] F_FIX     = 4'd7;
	localparam logic [FI_W-1:0] F_BARO    = 4'd8;
	localparam logic [FI_W-1:0] F_GPS_ALT = 4'd9;
	localparam logic [FI_W-1:0] F_GPS_OUT = 4'd10;
	localparam logic [FI_W-1:0] F_END     = 4'd11;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [1:0] {
		K_CHAR,
		K_CRLF,
		K_ALT
	} kind_t;

	typedef logic [ALT_DIGITS-1:0][7:0] digits_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] chr;
		digits_t    digits;
	} entry_t;

endpackage

/* rtl/core/gga2igc_front.sv */
// Front end: accepts beats, tracks sentence fields and altitude buffer, queues output work.
module gga2igc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [16:0]           baro_altitude,
	input  logic [7:0]            data_byte,
	input  logic                  q_full,
	output logic                  push,
	output gga2igc_pkg::entry_t   entry
);

	typedef enum logic {
		ST_IDLE,
		ST_CONV
	} state_t;

	state_t                                   state_q;
	logic [gga2igc_pkg::FI_W-1:0]             fi_q, fi_n, fi_inc;
	logic [gga2igc_pkg::DL_W-1:0]             dl_q, dl_n, dl_m1;
	gga2igc_pkg::digits_t                     buf_q, buf_n, shifted, conv_buf;
	logic [gga2igc_pkg::VAL_W-1:0]            val_q, quot, quot10;
	logic [2*gga2igc_pkg::VAL_W-1:0]          prod;
	logic [3:0]                               rem;
	logic [gga2igc_pkg::AI_W-1:0]             cnt_q;
	logic                                     acc;
	logic                                     start;

	assign in_ready = (state_q == ST_IDLE) && !q_full;
	assign acc      = in_valid && in_ready;
	assign start    = acc && !opcode;

	assign fi_inc = (fi_q < gga2igc_pkg::FIELD_MAX) ? fi_q + 1'b1 : fi_q;
	assign dl_m1  = dl_q - 1'b1;

	// The dot right-justifies the captured characters: drop the free slots at the bottom.
	always_comb begin
		shifted = buf_q >> {dl_q, 3'b000};
		for (int i = 0; i < gga2igc_pkg::ALT_DIGITS; i++) begin
			if (({1'b0, dl_q} + (gga2igc_pkg::DL_W+1)'(i))
					>= (gga2igc_pkg::DL_W+1)'(gga2igc_pkg::ALT_DIGITS)) begin
				shifted[i] = gga2igc_pkg::CH_ZERO;
			end
		end
	end

	// One decimal digit per cycle, ones digit first, shifted in from the top.
	assign prod   = val_q * gga2igc_pkg::RECIP_TEN;
	assign quot   = gga2igc_pkg::VAL_W'(prod[2*gga2igc_pkg::VAL_W-1:gga2igc_pkg::RECIP_SHIFT]);
	assign quot10 = (quot << 3) + (quot << 1);
	assign rem    = 4'(val_q - quot10);

	always_comb begin
		for (int i = 0; i < gga2igc_pkg::ALT_DIGITS - 1; i++) begin
			conv_buf[i] = buf_q[i+1];
		end
		conv_buf[gga2igc_pkg::ALT_DIGITS-1] = gga2igc_pkg::CH_ZERO | {4'b0000, rem};
	end

	always_comb begin
		fi_n         = fi_q;
		dl_n         = dl_q;
		buf_n        = buf_q;
		push         = 1'b0;
		entry.kind   = gga2igc_pkg::K_CHAR;
		entry.chr    = gga2igc_pkg::CH_B;
		entry.digits = buf_q;
		if (acc) begin
			if (!opcode) begin
				push = 1'b1;
				fi_n = gga2igc_pkg::F_TIME;
				dl_n = gga2igc_pkg::DL_W'(gga2igc_pkg::TIME_DIGITS);
			end else if (data_byte == gga2igc_pkg::CH_COMMA) begin
				fi_n = fi_inc;
				case (fi_inc)
					gga2igc_pkg::F_LAT: dl_n = gga2igc_pkg::DL_W'(gga2igc_pkg::LAT_DIGITS);
					gga2igc_pkg::F_HEMI_NS,
					gga2igc_pkg::F_HEMI_EW: dl_n = gga2igc_pkg::DL_W'(gga2igc_pkg::HEMI_DIGITS);
					gga2igc_pkg::F_LON: dl_n = gga2igc_pkg::DL_W'(gga2igc_pkg::LON_DIGITS);
					gga2igc_pkg::F_FIX: begin
						push      = 1'b1;
						entry.chr = gga2igc_pkg::CH_A;
					end
					gga2igc_pkg::F_BARO,
					gga2igc_pkg::F_GPS_OUT: begin
						push       = 1'b1;
						entry.kind = gga2igc_pkg::K_ALT;
						dl_n       = '0;
					end
					gga2igc_pkg::F_GPS_ALT: dl_n = gga2igc_pkg::DL_W'(gga2igc_pkg::ALT_DIGITS);
					gga2igc_pkg::F_END: begin
						push       = 1'b1;
						entry.kind = gga2igc_pkg::K_CRLF;
					end
					default: ;
				endcase
			end else if (fi_q == gga2igc_pkg::F_GPS_ALT) begin
				// Slots fill from the top down; once the dot is seen the count sits above
				// the buffer size and the rest of the field is ignored.
				if (dl_q <= gga2igc_pkg::DL_W'(gga2igc_pkg::ALT_DIGITS)) begin
					if (data_byte != gga2igc_pkg::CH_DOT) begin
						if (dl_q != '0) begin
							dl_n = dl_m1;
							for (int i = 0; i < gga2igc_pkg::ALT_DIGITS; i++) begin
								if (dl_m1 == gga2igc_pkg::DL_W'(i)) begin
									buf_n[i] = data_byte;
								end
							end
						end
					end else begin
						buf_n = shifted;
						dl_n  = gga2igc_pkg::DL_W'(gga2igc_pkg::ALT_DIGITS + 1);
					end
				end
			end else if (fi_q < gga2igc_pkg::F_BARO && data_byte != gga2igc_pkg::CH_DOT
					&& dl_q != '0) begin
				dl_n      = dl_m1;
				push      = 1'b1;
				entry.chr = data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fi_q    <= '0;
			dl_q    <= '0;
			buf_q   <= '0;
			val_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					fi_q  <= fi_n;
					dl_q  <= dl_n;
					buf_q <= buf_n;
					if (start) begin
						state_q <= ST_CONV;
						val_q   <= baro_altitude[16] ? '0 : baro_altitude[15:0];
						cnt_q   <= gga2igc_pkg::AI_W'(gga2igc_pkg::ALT_DIGITS - 1);
					end
				end
				ST_CONV: begin
					buf_q <= conv_buf;
					val_q <= quot;
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_start_converts: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == ST_CONV)
		else $error("start beat did not begin altitude conversion");
	a_conv_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> !in_ready && !push)
		else $error("front accepted or queued work during conversion");
`endif

endmodule

/* rtl/core/gga2igc_fifo.sv */
// Short register queue of output work between the front and back ends.
module gga2igc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  gga2igc_pkg::entry_t   din,
	output logic                  full,
	input  logic                  pop,
	output gga2igc_pkg::entry_t   dout,
	output logic                  empty
);

	gga2igc_pkg::entry_t                   mem_q [gga2igc_pkg::QDEPTH];
	logic [gga2igc_pkg::QPTR_W-1:0]        wr_q, rd_q;
	logic [gga2igc_pkg::QCNT_W-1:0]        cnt_q;

	assign full  = cnt_q == gga2igc_pkg::QCNT_W'(gga2igc_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == gga2igc_pkg::QPTR_W'(gga2igc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == gga2igc_pkg::QPTR_W'(gga2igc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

/* rtl/core/gga2igc_back.sv */
// Back end: expands queued work into output character beats behind an output register.
module gga2igc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gga2igc_pkg::entry_t   entry,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_char,
	output logic                  out_last
);

	logic                           busy_q;
	gga2igc_pkg::kind_t             kind_q;
	logic [7:0]                     chr_q;
	gga2igc_pkg::digits_t           dig_q, dig_shift;
	logic [gga2igc_pkg::AI_W-1:0]   idx_q;
	logic                           m_valid_q, m_last_q;
	logic [7:0]                     m_data_q;
	logic [7:0]                     cur_char;
	logic                           cur_last;
	logic                           out_free;

	assign out_valid = m_valid_q;
	assign out_char  = m_data_q;
	assign out_last  = m_last_q;
	assign out_free  = !m_valid_q || out_ready;
	assign pop       = !busy_q && !q_empty;

	// Altitude digits leave from the most significant end.
	always_comb begin
		for (int i = 1; i < gga2igc_pkg::ALT_DIGITS; i++) begin
			dig_shift[i] = dig_q[i-1];
		end
		dig_shift[0] = gga2igc_pkg::CH_ZERO;
	end

	always_comb begin
		case (kind_q)
			gga2igc_pkg::K_CHAR: begin
				cur_char = chr_q;
				cur_last = 1'b1;
			end
			gga2igc_pkg::K_CRLF: begin
				cur_char = (idx_q == '0) ? gga2igc_pkg::CH_CR : gga2igc_pkg::CH_LF;
				cur_last = idx_q != '0;
			end
			gga2igc_pkg::K_ALT: begin
				cur_char = dig_q[gga2igc_pkg::ALT_DIGITS-1];
				cur_last = idx_q == gga2igc_pkg::AI_W'(gga2igc_pkg::ALT_DIGITS - 1);
			end
			default: begin
				cur_char = chr_q;
				cur_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			kind_q    <= gga2igc_pkg::K_CHAR;
			chr_q     <= '0;
			dig_q     <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_last_q  <= 1'b0;
		end else begin
			if (busy_q && out_free) begin
				m_valid_q <= 1'b1;
				m_data_q  <= cur_char;
				m_last_q  <= cur_last;
				dig_q     <= dig_shift;
				if (cur_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else begin
				if (m_valid_q && out_ready) begin
					m_valid_q <= 1'b0;
				end
				if (pop) begin
					busy_q <= 1'b1;
					kind_q <= entry.kind;
					chr_q  <= entry.chr;
					dig_q  <= entry.digits;
					idx_q  <= '0;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_crlf_two_beats: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == gga2igc_pkg::K_CRLF |-> idx_q <= gga2igc_pkg::AI_W'(1))
		else $error("line end entry ran past its two beats");
`endif

endmodule

/* rtl/core/nmea_gga_to_igc_b_record.sv */
// Top level of the GPS fix sentence to flight-log B record rewriter.
// A start beat (tuser 0) emits 'B' and converts the barometric altitude to decimal digits,
// which holds off s_tready after the start beat until every altitude digit is produced.
// A sentence byte beat (tuser 1) is taken when s_tready is high. Output characters come from a
// two-entry work queue at one beat per cycle while m_tready allows, with an idle gap between
// queued entries, so a byte that ends a field may produce up to five beats (an altitude).
// Input is stalled only while the conversion runs or the work queue is full.
module nmea_gga_to_igc_b_record (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [16:0] baro_altitude, [24:17] data_byte, [31:25] zero
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic        m_tlast
);

	gga2igc_pkg::entry_t push_entry, pop_entry;
	logic                push, pop, q_full, q_empty;

	gga2igc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.opcode        (s_tuser),
		.baro_altitude (s_tdata[16:0]),
		.data_byte     (s_tdata[24:17]),
		.q_full        (q_full),
		.push          (push),
		.entry         (push_entry)
	);

	gga2igc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.full   (q_full),
		.pop    (pop),
		.dout   (pop_entry),
		.empty  (q_empty)
	);

	gga2igc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (pop_entry),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
